FILE: rtl/waws_pkg.sv
// ----------------------------------------------------------------------------
// waws_pkg
// Shared types and constants for the word anagram window search block.
// ----------------------------------------------------------------------------
package waws_pkg;

    localparam int SYM_W      = 8;
    localparam int KIND_W     = 2;
    localparam int CFG_W      = 7;
    localparam int CNT_W      = 7;
    localparam int HIST_DEPTH = 256;
    localparam int OFS_W      = 8;
    localparam int WORD_W     = 16;
    localparam int DIST_W     = 9;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // histogram operation carried down the pipeline
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_WCLEAR,
        OP_TEXT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SYM_W-1:0]  sym;
        logic              has_gone;
        logic              full;
        logic [OFS_W-1:0]  start;
        logic [WORD_W-1:0] word_num;
    } item_t;

    // match sits in the lowest bit
    typedef struct packed {
        logic [WORD_W-1:0] total;
        logic [WORD_W-1:0] word_num;
        logic [OFS_W-1:0]  start;
        logic              match;
    } result_t;

    localparam int RES_W       = $bits(result_t);
    localparam int RES_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_LVL_W = 3;

endpackage

FILE: rtl/word_anagram_window_search_top.sv
// ----------------------------------------------------------------------------
// word_anagram_window_search_top
// Pipeline: the recent-byte ring read, the histogram read and the histogram
// update into the queue are registered in turn before a result reaches m_tvalid.
// Throughput: one item per cycle while s_tready is high; the histogram
// memories forward the last write so back-to-back bytes of one symbol need no stall.
// Reset: synchronous, active low; clears control state and all histogram
// valid bits at once, so no clearing pass is needed and items are taken at once.
// ----------------------------------------------------------------------------
module word_anagram_window_search_top
    import waws_pkg::*;
#(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_WORD    = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SYM_W-1:0]       s_tdata,    // [7:0] symbol
    input  logic [KIND_W-1:0]      s_tuser,    // [1:0] kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [RES_TDATA_W-1:0] m_tdata,    // [0] match, [8:1] start_offset,
                                               // [24:9] word_number,
                                               // [40:25] match_total, rest zero
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata   // pattern_length
);

    logic                 in_accept;
    logic                 st1_valid;
    item_t                st1_item;
    logic [SYM_W-1:0]     st1_gone;
    logic                 res_valid;
    result_t              res;
    result_t              fifo_data;
    logic [OUT_LVL_W-1:0] fifo_level;
    logic [OUT_LVL_W-1:0] in_flight;

    // leave room in the queue for every item still in the pipeline
    assign in_flight = fifo_level + OUT_LVL_W'(st1_valid) + OUT_LVL_W'(res_valid);
    assign s_tready  = (in_flight < OUT_LVL_W'(OUT_DEPTH));
    assign in_accept = s_tvalid && s_tready;

    waws_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_WORD    (MAX_WORD)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_kind   (s_tuser),
        .in_sym    (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .st1_valid (st1_valid),
        .st1_item  (st1_item),
        .st1_gone  (st1_gone)
    );

    waws_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .st1_valid (st1_valid),
        .st1_item  (st1_item),
        .st1_gone  (st1_gone),
        .cfg_we    (cfg_we),
        .res_valid (res_valid),
        .res       (res)
    );

    waws_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (fifo_data),
        .level     (fifo_level)
    );

    assign m_tdata = RES_TDATA_W'(fifo_data);

endmodule

FILE: rtl/waws_hist_mem.sv
// ----------------------------------------------------------------------------
// waws_hist_mem
// 256-entry symbol count memory: one write port, two registered read ports,
// per-entry valid bits cleared at once, and forwarding of the last write.
// ----------------------------------------------------------------------------
module waws_hist_mem
    import waws_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr,
    input  logic             we,
    input  logic [SYM_W-1:0] waddr,
    input  logic [CNT_W-1:0] wdata,
    input  logic [SYM_W-1:0] raddr_a,
    input  logic [SYM_W-1:0] raddr_b,
    output logic [CNT_W-1:0] rdata_a,
    output logic [CNT_W-1:0] rdata_b
);

    logic [CNT_W-1:0]      mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] valid_reg, valid_next;
    logic [SYM_W-1:0]      raddr_a_reg, raddr_b_reg, last_addr_reg;
    logic [CNT_W-1:0]      rd_a_reg, rd_b_reg, last_data_reg;
    logic                  last_we_reg;

    always_comb begin
        valid_next = valid_reg;
        if (clr) begin
            valid_next = '0;
        end
        if (we) begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            last_we_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            last_we_reg <= we;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_a_reg      <= mem[raddr_a];
        rd_b_reg      <= mem[raddr_b];
        raddr_a_reg   <= raddr_a;
        raddr_b_reg   <= raddr_b;
        last_addr_reg <= waddr;
        last_data_reg <= wdata;
    end

    // the read registered at the last edge missed the write of that same edge
    always_comb begin
        if (!valid_reg[raddr_a_reg]) begin
            rdata_a = '0;
        end else if (last_we_reg && (last_addr_reg == raddr_a_reg)) begin
            rdata_a = last_data_reg;
        end else begin
            rdata_a = rd_a_reg;
        end
        if (!valid_reg[raddr_b_reg]) begin
            rdata_b = '0;
        end else if (last_we_reg && (last_addr_reg == raddr_b_reg)) begin
            rdata_b = last_data_reg;
        end else begin
            rdata_b = rd_b_reg;
        end
    end

endmodule

FILE: rtl/waws_front.sv
// ----------------------------------------------------------------------------
// waws_front
// Input stage: word tracking, window width, word counter and the ring of
// recent text bytes that yields the byte leaving the window.
// ----------------------------------------------------------------------------
module waws_front
    import waws_pkg::*;
#(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_WORD    = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [KIND_W-1:0] in_kind,
    input  logic [SYM_W-1:0]  in_sym,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output logic              st1_valid,
    output item_t             st1_item,
    output logic [SYM_W-1:0]  st1_gone
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int POS_W = $clog2(MAX_WORD + 1);
    localparam int CW_A  = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int CW    = ((CW_A > OFS_W) ? CW_A : OFS_W) + 2;

    logic [SYM_W-1:0]  recent_mem [MAX_PATTERN];

    logic [CFG_W-1:0]  plen_reg, plen_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [WORD_W-1:0] wc_reg, wc_next;
    logic              st1_valid_reg;
    item_t             st1_item_reg, item_next;
    logic [SYM_W-1:0]  gone_reg;
    logic              rec_we;

    logic [LEN_W-1:0]  win_len;
    logic [CW-1:0]     len_x, pos_x, ptr_x, ofs_x, rd_x;

    function automatic logic is_space(input logic [SYM_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // zero acts as one, oversize clamps to the ring depth
    always_comb begin
        if (plen_reg == '0) begin
            win_len = LEN_W'(1);
        end else if (CW'(plen_reg) > CW'(MAX_PATTERN)) begin
            win_len = LEN_W'(MAX_PATTERN);
        end else begin
            win_len = LEN_W'(plen_reg);
        end
    end

    always_comb begin
        len_x = CW'(win_len);
        pos_x = CW'(pos_reg);
        ptr_x = CW'(ptr_reg);
        ofs_x = pos_x + CW'(1) - len_x;
        rd_x  = (ptr_x >= len_x) ? (ptr_x - len_x) : (ptr_x + CW'(MAX_PATTERN) - len_x);

        plen_next = plen_reg;
        pos_next  = pos_reg;
        ptr_next  = ptr_reg;
        wc_next   = wc_reg;
        rec_we    = 1'b0;

        item_next.op       = OP_NOP;
        item_next.sym      = in_sym;
        item_next.has_gone = 1'b0;
        item_next.full     = 1'b0;
        item_next.start    = '0;

        if (cfg_we) begin
            plen_next = cfg_wdata;
            pos_next  = '0;
            ptr_next  = '0;
        end else if (in_accept) begin
            case (in_kind)
                KIND_LOAD: begin
                    item_next.op = OP_LOAD;
                    pos_next     = '0;
                    ptr_next     = '0;
                end
                KIND_CLEAR: begin
                    item_next.op = OP_CLEAR;
                    pos_next     = '0;
                    ptr_next     = '0;
                end
                KIND_TEXT: begin
                    if (is_space(in_sym)) begin
                        // runs of whitespace count as one separator
                        if (pos_reg != '0) begin
                            if (wc_reg != '1) begin
                                wc_next = wc_reg + 1'b1;
                            end
                            item_next.op = OP_WCLEAR;
                            pos_next     = '0;
                            ptr_next     = '0;
                        end
                    end else if (pos_x < CW'(MAX_WORD)) begin
                        item_next.op       = OP_TEXT;
                        item_next.has_gone = (pos_x >= len_x);
                        item_next.full     = ((pos_x + CW'(1)) >= len_x);
                        if (ofs_x > CW'({OFS_W{1'b1}})) begin
                            item_next.start = '1;
                        end else begin
                            item_next.start = ofs_x[OFS_W-1:0];
                        end
                        rec_we   = 1'b1;
                        pos_next = pos_reg + 1'b1;
                        ptr_next = (ptr_x == CW'(MAX_PATTERN - 1)) ? '0 : (ptr_reg + 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
        item_next.word_num = wc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg      <= CFG_W'(1);
            pos_reg       <= '0;
            ptr_reg       <= '0;
            wc_reg        <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            plen_reg      <= plen_next;
            pos_reg       <= pos_next;
            ptr_reg       <= ptr_next;
            wc_reg        <= wc_next;
            st1_valid_reg <= in_accept;
        end
    end

    // read-before-write: at full ring width the leaving byte shares the slot
    always_ff @(posedge aclk) begin
        if (rec_we) begin
            recent_mem[ptr_reg] <= in_sym;
        end
        gone_reg     <= recent_mem[rd_x[PTR_W-1:0]];
        st1_item_reg <= item_next;
    end

    assign st1_valid = st1_valid_reg;
    assign st1_item  = st1_item_reg;
    assign st1_gone  = gone_reg;

endmodule

FILE: rtl/waws_core.sv
// ----------------------------------------------------------------------------
// waws_core
// Histogram stage: pattern counts and window counts (as entry and exit
// tallies), differing-symbol count, match decision and match counter.
// ----------------------------------------------------------------------------
module waws_core
    import waws_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             st1_valid,
    input  item_t            st1_item,
    input  logic [SYM_W-1:0] st1_gone,
    input  logic             cfg_we,
    output logic             res_valid,
    output result_t          res
);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic              st2_valid_reg;
    item_t             st2_item_reg;
    logic [SYM_W-1:0]  st2_gone_reg;

    logic [DIST_W-1:0] differ_reg, differ_next;
    logic [DIST_W-1:0] distinct_reg, distinct_next;
    logic [WORD_W-1:0] found_reg, found_next;

    logic              win_clr, pat_clr, inc_we, dec_we, pat_we;
    logic [CNT_W-1:0]  inc_wdata, dec_wdata, pat_wdata;
    logic [CNT_W-1:0]  inc_g, inc_s, dec_g, dec_s, pat_g, pat_s;
    logic [CNT_W-1:0]  win_g, win_s, wg_new, ws_old, ws_new;
    logic [DIST_W-1:0] d;
    logic              match;

    // window count of a symbol = entries minus exits, modulo the count width
    waws_hist_mem u_inc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (win_clr),
        .we      (inc_we),
        .waddr   (st2_item_reg.sym),
        .wdata   (inc_wdata),
        .raddr_a (st1_gone),
        .raddr_b (st1_item.sym),
        .rdata_a (inc_g),
        .rdata_b (inc_s)
    );

    waws_hist_mem u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (win_clr),
        .we      (dec_we),
        .waddr   (st2_gone_reg),
        .wdata   (dec_wdata),
        .raddr_a (st1_gone),
        .raddr_b (st1_item.sym),
        .rdata_a (dec_g),
        .rdata_b (dec_s)
    );

    waws_hist_mem u_pat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (pat_clr),
        .we      (pat_we),
        .waddr   (st2_item_reg.sym),
        .wdata   (pat_wdata),
        .raddr_a (st1_gone),
        .raddr_b (st1_item.sym),
        .rdata_a (pat_g),
        .rdata_b (pat_s)
    );

    always_comb begin
        differ_next   = differ_reg;
        distinct_next = distinct_reg;
        found_next    = found_reg;
        win_clr       = 1'b0;
        pat_clr       = 1'b0;
        inc_we        = 1'b0;
        dec_we        = 1'b0;
        pat_we        = 1'b0;
        inc_wdata     = inc_s + 1'b1;
        dec_wdata     = dec_g + 1'b1;
        pat_wdata     = pat_s + 1'b1;
        win_g         = inc_g - dec_g;
        win_s         = inc_s - dec_s;
        wg_new        = win_g;
        ws_old        = win_s;
        ws_new        = win_s;
        d             = differ_reg;
        match         = 1'b0;

        if (cfg_we) begin
            win_clr     = 1'b1;
            differ_next = distinct_reg;
        end else if (st2_valid_reg) begin
            case (st2_item_reg.op)
                OP_LOAD: begin
                    if (pat_s == '0) begin
                        distinct_next = distinct_reg + 1'b1;
                    end
                    pat_we      = (pat_s != CNT_MAX);
                    win_clr     = 1'b1;
                    differ_next = distinct_next;
                end
                OP_CLEAR: begin
                    pat_clr       = 1'b1;
                    win_clr       = 1'b1;
                    distinct_next = '0;
                    differ_next   = '0;
                end
                OP_WCLEAR: begin
                    win_clr     = 1'b1;
                    differ_next = distinct_reg;
                end
                OP_TEXT: begin
                    // drop the leaving byte first, then add the new one
                    if (st2_item_reg.has_gone) begin
                        if (win_g != '0) begin
                            wg_new = win_g - 1'b1;
                            dec_we = 1'b1;
                        end
                        if ((win_g == pat_g) && (wg_new != pat_g)) begin
                            d = d + 1'b1;
                        end else if ((win_g != pat_g) && (wg_new == pat_g) && (d != '0)) begin
                            d = d - 1'b1;
                        end
                    end
                    if (st2_item_reg.has_gone && (st2_item_reg.sym == st2_gone_reg)) begin
                        ws_old = wg_new;
                    end
                    ws_new = ws_old;
                    if (ws_old != CNT_MAX) begin
                        ws_new = ws_old + 1'b1;
                        inc_we = 1'b1;
                    end
                    if ((ws_old == pat_s) && (ws_new != pat_s)) begin
                        d = d + 1'b1;
                    end else if ((ws_old != pat_s) && (ws_new == pat_s) && (d != '0)) begin
                        d = d - 1'b1;
                    end
                    differ_next = d;
                    if (st2_item_reg.full && (d == '0)) begin
                        match = 1'b1;
                        if (found_reg != '1) begin
                            found_next = found_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
            differ_reg    <= '0;
            distinct_reg  <= '0;
            found_reg     <= '0;
        end else begin
            st2_valid_reg <= st1_valid;
            differ_reg    <= differ_next;
            distinct_reg  <= distinct_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        st2_item_reg <= st1_item;
        st2_gone_reg <= st1_gone;
    end

    assign res_valid    = st2_valid_reg;
    assign res.match    = match;
    assign res.start    = match ? st2_item_reg.start : '0;
    assign res.word_num = st2_item_reg.word_num;
    assign res.total    = found_next;

endmodule

FILE: rtl/waws_out_fifo.sv
// ----------------------------------------------------------------------------
// waws_out_fifo
// Small result queue that absorbs the in-flight items while the output
// side stalls.
// ----------------------------------------------------------------------------
module waws_out_fifo
    import waws_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  result_t              push_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output result_t              out_data,
    output logic [OUT_LVL_W-1:0] level
);

    localparam int PTR_W = $clog2(OUT_DEPTH);

    result_t              fifo_mem [OUT_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [OUT_LVL_W-1:0] count_reg, count_next;
    logic                 pop;

    always_comb begin
        pop         = (count_reg != '0) && out_ready;
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + OUT_LVL_W'(push) - OUT_LVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = fifo_mem[rd_ptr_reg];
    assign level     = count_reg;

endmodule

FILE: rtl/waws_checker.sv
// ----------------------------------------------------------------------------
// waws_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module waws_checker
    import waws_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [RES_TDATA_W-1:0] m_tdata
);

    result_t res_view;

    assign res_view = result_t'(m_tdata[RES_W-1:0]);

    // queue comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // a rising result valid must trace back to an input transaction through the front, core and queue registers
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
        else $error("result appeared without a matching input transaction");

    a_offset_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res_view.match |-> res_view.start == '0)
        else $error("start offset nonzero on a non-matching result");

    a_total_on_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_view.match |-> res_view.total != '0)
        else $error("match reported with zero match total");

endmodule

bind word_anagram_window_search_top waws_checker u_waws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the word anagram window search block. Pattern, text,
// clear and spare-kind items go in over the input stream. An in-bench
// histogram predictor computes the result of each accepted transaction.
// Each result transaction is compared field by field with the oldest
// prediction. Both stream sides idle at random, except during one steady
// stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import waws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PATTERN   = 64;
    localparam int MAX_WORD      = 256;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 500;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
    localparam logic [WORD_W-1:0] TOTAL_MAX  = '1;
    localparam logic [SYM_W-1:0]  BLANKS [6] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SYM_W-1:0]       s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [RES_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    bit          steady_stretch = 1'b0;
    int unsigned items_sent = 0;
    int unsigned fail_count = 0;
    result_t     pending_results [$];

    // predictor state
    logic [CNT_W-1:0]  pat_hist [HIST_DEPTH];
    logic [CNT_W-1:0]  win_hist [HIST_DEPTH];
    logic [SYM_W-1:0]  tail_bytes [MAX_PATTERN];
    int unsigned       word_pos;
    int unsigned       diff_syms;
    int unsigned       pat_distinct;
    logic [WORD_W-1:0] word_cnt;
    logic [WORD_W-1:0] found_cnt;
    logic [CFG_W-1:0]  len_reg;

    word_anagram_window_search_top #(
        .MAX_PATTERN(MAX_PATTERN),
        .MAX_WORD   (MAX_WORD)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit is_blank(input logic [SYM_W-1:0] sym);
        return sym == 8'h20 || (sym >= 8'h09 && sym <= 8'h0D);
    endfunction

    function automatic int unsigned window_width();
        if (len_reg == '0) return 1;
        if (int'(len_reg) > MAX_PATTERN) return MAX_PATTERN;
        return int'(len_reg);
    endfunction

    function automatic void clear_window_model();
        foreach (win_hist[i]) win_hist[i] = '0;
        word_pos  = 0;
        diff_syms = pat_distinct;
    endfunction

    function automatic void reset_model();
        foreach (pat_hist[i]) pat_hist[i] = '0;
        foreach (tail_bytes[i]) tail_bytes[i] = '0;
        len_reg      = 7'd1;
        pat_distinct = 0;
        word_cnt     = '0;
        found_cnt    = '0;
        clear_window_model();
    endfunction

    // move one symbol into or out of the window and track differing symbols
    function automatic void bump_window(input logic [SYM_W-1:0] sym, input bit up);
        bit was_eq;
        bit now_eq;
        was_eq = win_hist[sym] == pat_hist[sym];
        if (up) begin
            if (win_hist[sym] != CNT_MAX) win_hist[sym] = win_hist[sym] + 1'b1;
        end else if (win_hist[sym] != '0) begin
            win_hist[sym] = win_hist[sym] - 1'b1;
        end
        now_eq = win_hist[sym] == pat_hist[sym];
        if (was_eq && !now_eq) diff_syms++;
        else if (!was_eq && now_eq && diff_syms > 0) diff_syms--;
    endfunction

    function automatic result_t predict_result(input logic [KIND_W-1:0] kind,
                                               input logic [SYM_W-1:0] sym);
        result_t     r;
        int unsigned w;
        int unsigned p;
        r = '0;
        case (kind)
            KIND_LOAD: begin
                if (pat_hist[sym] == '0) pat_distinct++;
                if (pat_hist[sym] != CNT_MAX) pat_hist[sym] = pat_hist[sym] + 1'b1;
                clear_window_model();
            end
            KIND_CLEAR: begin
                foreach (pat_hist[i]) pat_hist[i] = '0;
                pat_distinct = 0;
                clear_window_model();
            end
            KIND_TEXT: begin
                if (is_blank(sym)) begin
                    if (word_pos > 0) begin
                        if (word_cnt != TOTAL_MAX) word_cnt = word_cnt + 1'b1;
                        clear_window_model();
                    end
                end else if (word_pos < MAX_WORD) begin
                    w = window_width();
                    p = word_pos;
                    if (p >= w) bump_window(tail_bytes[(p - w) % MAX_PATTERN], 1'b0);
                    tail_bytes[p % MAX_PATTERN] = sym;
                    bump_window(sym, 1'b1);
                    word_pos = p + 1;
                    if (word_pos >= w && diff_syms == 0) begin
                        r.match = 1'b1;
                        r.start = (word_pos - w > 255) ? 8'hFF : 8'(word_pos - w);
                        if (found_cnt != TOTAL_MAX) found_cnt = found_cnt + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.word_num = word_cnt;
        r.total    = found_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stream monitors
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            pending_results.push_back(predict_result(s_tuser, s_tdata));
    end

    always @(posedge aclk) begin
        m_tready <= steady_stretch || ($urandom_range(99) >= 16);
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want != got) begin
            fail_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    function automatic void check_result(input logic [RES_TDATA_W-1:0] data);
        result_t got;
        result_t want;
        got = data[RES_W-1:0];
        if (pending_results.size() == 0) begin
            fail_count++;
            $error("result transaction with no prediction pending");
        end else begin
            want = pending_results.pop_front();
            check_field("match", 32'(want.match), 32'(got.match));
            check_field("start_offset", 32'(want.start), 32'(got.start));
            check_field("word_number", 32'(want.word_num), 32'(got.word_num));
            check_field("match_total", 32'(want.total), 32'(got.total));
            check_field("tdata_pad", 32'd0, 32'(data[RES_TDATA_W-1:RES_W]));
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Leaves s_tvalid high on return unless a gap was taken; callers either
    // send the next transaction or call wait_drained in the same step.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= sym;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (!steady_stretch && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_item(KIND_TEXT, txt[i]);
    endtask

    // hold input until every predicted result is back, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        len_reg = value;
        clear_window_model();
    endtask

    task automatic shuffle_bytes(ref logic [SYM_W-1:0] q [$]);
        logic [SYM_W-1:0] t;
        int unsigned      j;
        for (int i = q.size() - 1; i > 0; i--) begin
            j    = $urandom_range(i, 0);
            t    = q[i];
            q[i] = q[j];
            q[j] = t;
        end
    endtask

    function automatic logic [SYM_W-1:0] alpha_sym(input logic [SYM_W-1:0] first,
                                                   input int unsigned count);
        return 8'(int'(first) + $urandom_range(count - 1, 0));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_basic_anagrams();
        wait_drained();
        write_length(7'd3);
        send_item(KIND_CLEAR, 8'hFF);
        send_text("abc");
        for (int i = 0; i < 3; i++) send_item(KIND_LOAD, 8'(8'h61 + i));
        send_text("cabc  ");
        send_item(KIND_TEXT, 8'h00);
        send_item(KIND_TEXT, 8'hFF);
        send_item(KIND_TEXT, 8'h08);
        send_item(KIND_TEXT, 8'h0E);
        send_item(KIND_TEXT, 8'h09);
        send_text("bca");
        send_item(KIND_TEXT, 8'h0A);
        send_text("a");
        send_item(KIND_TEXT, 8'h0B);
        send_item(KIND_TEXT, 8'h0C);
        send_item(KIND_TEXT, 8'h0D);
        send_item(KIND_SPARE, 8'h61);
    endtask

    task automatic test_length_extremes();
        logic [SYM_W-1:0] perm [$];
        // zero acts as a width of one
        wait_drained();
        write_length(7'd0);
        send_item(KIND_CLEAR, 8'h00);
        send_item(KIND_LOAD, 8'h71);
        send_text("qqxq ");
        // widths above the maximum clamp to it
        wait_drained();
        write_length(7'd127);
        send_item(KIND_CLEAR, 8'h55);
        for (int i = 0; i < MAX_PATTERN; i++) perm.push_back(8'(8'h80 + i));
        foreach (perm[i]) send_item(KIND_LOAD, perm[i]);
        shuffle_bytes(perm);
        foreach (perm[i]) send_item(KIND_TEXT, perm[i]);
        send_item(KIND_TEXT, perm[0]);
        send_text(" ");
        wait_drained();
        write_length(7'd64);
        shuffle_bytes(perm);
        foreach (perm[i]) send_item(KIND_TEXT, perm[i]);
        send_text(" ");
    endtask

    task automatic test_midword_length_write();
        wait_drained();
        write_length(7'd2);
        send_item(KIND_CLEAR, 8'h00);
        send_text("mn");
        send_text("mnm");
        // rewrite mid-word: offsets restart from here
        wait_drained();
        write_length(7'd2);
        send_text("nmn");
        // pattern is empty after the clear, window three: nothing can match
        wait_drained();
        write_length(7'd3);
        send_text("mnm nmm ");
    endtask

    task automatic test_long_word();
        wait_drained();
        write_length(7'd1);
        send_item(KIND_CLEAR, 8'h00);
        send_item(KIND_LOAD, 8'h61);
        repeat (MAX_WORD + 4) send_item(KIND_TEXT, 8'h61);
        send_text(" a ");
    endtask

    task automatic test_pattern_saturation();
        wait_drained();
        write_length(7'd64);
        send_item(KIND_CLEAR, 8'h00);
        repeat (130) send_item(KIND_LOAD, 8'h7A);
        send_text("zzzz ");
        send_item(KIND_CLEAR, 8'h7A);
        send_text("zz ");
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] len_cfg;
        logic [SYM_W-1:0] pat [$];
        logic [SYM_W-1:0] word [$];
        logic [SYM_W-1:0] mixed [$];
        logic [SYM_W-1:0] first;
        int unsigned      eff;
        int unsigned      n_load;
        int unsigned      n_alpha;
        int unsigned      phase;
        int unsigned      base;
        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            wait_drained();
            steady_stretch = phase >= 2 && phase < 6;
            case ($urandom_range(11))
                0: len_cfg = 7'd0;
                1: len_cfg = 7'd127;
                2: len_cfg = 7'($urandom_range(64, 9));
                default: len_cfg = 7'($urandom_range(8, 1));
            endcase
            write_length(len_cfg);
            eff = window_width();
            n_load = eff;
            if ($urandom_range(7) == 0) n_load = eff + 1;
            else if ($urandom_range(7) == 0 && eff > 1) n_load = eff - 1;
            n_alpha = $urandom_range(6, 2);
            first   = 8'($urandom_range(8'hF9, 8'h0E));
            // keep the old pattern now and then: only the length changed
            if (phase == 0 || $urandom_range(5) != 0) begin
                send_item(KIND_CLEAR, 8'($urandom));
                pat.delete();
                repeat (n_load) pat.push_back(alpha_sym(first, n_alpha));
                foreach (pat[i]) send_item(KIND_LOAD, pat[i]);
            end
            repeat ($urandom_range(6, 2)) begin
                word.delete();
                if ($urandom_range(9) < 6) begin
                    repeat ($urandom_range(4, 0)) word.push_back(alpha_sym(first, n_alpha));
                    mixed = pat;
                    shuffle_bytes(mixed);
                    word = {word, mixed};
                    repeat ($urandom_range(4, 0)) word.push_back(alpha_sym(first, n_alpha));
                end else begin
                    repeat ($urandom_range(12, 1)) word.push_back(alpha_sym(first, n_alpha));
                end
                foreach (word[i]) send_item(KIND_TEXT, word[i]);
                if ($urandom_range(9) == 0)
                    send_item(2'($urandom_range(3, 0)), 8'($urandom));
                repeat ($urandom_range(3, 1))
                    send_item(KIND_TEXT, BLANKS[$urandom_range(5, 0)]);
            end
            // leave a word open so the next length write lands mid-word
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(5, 1)) send_item(KIND_TEXT, alpha_sym(first, n_alpha));
            phase++;
        end
        steady_stretch = 1'b0;
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        reset_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_basic_anagrams();
        test_length_extremes();
        test_midword_length_write();
        test_long_word();
        test_pattern_saturation();
        test_random_traffic();
        wait_drained();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
